/* hdl/mcs_pkg.sv */
`default_nettype none

package mcs_pkg;

    // Channel layout
    localparam int NUM_CH     = 7;
    localparam int NUM_RAMP   = 3;
    localparam int FIRST_RAMP = 4;
    localparam int NUM_DIR    = 5;

    // Field widths
    localparam int CMD_W = 16;
    localparam int MAG_W = 12;
    localparam int VAL_W = 13;
    localparam int DIR_W = 2;
    localparam int IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_CLAMP_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEADBAND    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SLEW_STEP   = 2'd2;

    // Reset values of the registers
    localparam logic [MAG_W-1:0] CLAMP_LIMIT_RST = 12'd1919;
    localparam logic [MAG_W-1:0] DEADBAND_RST    = 12'd150;
    localparam logic [MAG_W-1:0] SLEW_STEP_RST   = 12'd16;

    // Direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_STOP    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef logic signed [VAL_W-1:0] val_t;

    // Settings shared by the lanes and the ramps
    typedef struct packed {
        logic [MAG_W-1:0] clamp_limit;
        logic [MAG_W-1:0] deadband;
        logic [MAG_W-1:0] slew_step;
    } cfg_t;

    // One finished result
    typedef struct packed {
        logic [NUM_CH-1:0][MAG_W-1:0]  pwm;
        logic [NUM_DIR-1:0][DIR_W-1:0] dir;
    } result_t;

endpackage

`default_nettype wire

/* hdl/mcs_lane.sv */
`default_nettype none

module mcs_lane
    import mcs_pkg::*;
(
    input  wire logic signed [CMD_W-1:0] cmd,
    input  wire cfg_t                    cfg,
    output val_t                         target
);

    logic signed [CMD_W:0] cmd_ext;
    logic signed [CMD_W:0] lim_pos;
    logic signed [CMD_W:0] lim_neg;
    logic signed [CMD_W:0] clamped;
    logic signed [CMD_W:0] mag;
    logic signed [CMD_W:0] dead_ext;

    // Clamp to plus or minus the limit
    always_comb
    begin
        cmd_ext  = {cmd[CMD_W-1], cmd};
        lim_pos  = signed'({{(CMD_W+1-MAG_W){1'b0}}, cfg.clamp_limit});
        lim_neg  = -lim_pos;
        dead_ext = signed'({{(CMD_W+1-MAG_W){1'b0}}, cfg.deadband});
        if (cmd_ext > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (cmd_ext < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = cmd_ext;
        end
    end

    // Drop commands inside the deadband
    always_comb
    begin
        mag = (clamped < 0) ? -clamped : clamped;
        if (mag < dead_ext)
        begin
            target = '0;
        end
        else
        begin
            target = clamped[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hdl/mcs_ramp.sv */
`default_nettype none

module mcs_ramp
    import mcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire val_t             target,
    input  wire logic [MAG_W-1:0] slew_step,
    output val_t                  value_next
);

    val_t                  value_reg;
    logic signed [VAL_W:0] cur_ext;
    logic signed [VAL_W:0] tgt_ext;
    logic signed [VAL_W:0] step_ext;
    logic signed [VAL_W:0] down;
    logic signed [VAL_W:0] up;

    // Step toward the target without passing it
    always_comb
    begin
        cur_ext  = {value_reg[VAL_W-1], value_reg};
        tgt_ext  = {target[VAL_W-1], target};
        step_ext = signed'({{(VAL_W+1-MAG_W){1'b0}}, slew_step});
        down     = cur_ext - step_ext;
        up       = cur_ext + step_ext;
        if (cur_ext > tgt_ext)
        begin
            value_next = (down < tgt_ext) ? target : down[VAL_W-1:0];
        end
        else if (cur_ext < tgt_ext)
        begin
            value_next = (up > tgt_ext) ? target : up[VAL_W-1:0];
        end
        else
        begin
            value_next = value_reg;
        end
    end

    // Advance the ramp on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (advance)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/mcs_merge.sv */
`default_nettype none

module mcs_merge
    import mcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire val_t [NUM_CH-1:0] vals,
    input  wire logic              out_stall,
    output logic                   busy,
    output logic                   out_valid,
    output result_t                result
);

    result_t new_res;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    take;

    // Form magnitudes and direction codes from the lane values
    always_comb
    begin
        new_res = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            new_res.pwm[i] = (vals[i] < 0) ? MAG_W'(-vals[i]) : vals[i][MAG_W-1:0];
        end
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (vals[i] > 0)
            begin
                new_res.dir[i] = DIR_FORWARD;
            end
            else if (vals[i] < 0)
            begin
                new_res.dir[i] = DIR_REVERSE;
            end
            else
            begin
                new_res.dir[i] = DIR_STOP;
            end
        end
    end

    // Output register plus skid slot
    always_comb
    begin
        take            = main_valid_reg && !out_stall;
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = accept;
                if (accept)
                begin
                    main_next = new_res;
                end
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_next       = new_res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = new_res;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign busy      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign result    = main_reg;

endmodule

`default_nettype wire

/* hdl/motor_command_shaper_core.sv */
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  --------------------------------------
// in       in_valid / in_stall   cmd_ch0 .. cmd_ch6 (16-bit signed)
// out      out_valid / out_stall pwm_ch0 .. pwm_ch6, dir_ch0 .. dir_ch4
// cfg      cfg_valid / cfg_ready cfg_index (2 bits), cfg_data (12 bits)
//
// One request per cycle sustained while in_stall is low; each result is registered before it appears.
// Seven lanes clamp and deadband in parallel; three ramp registers update on accept.
// A two-entry output register/skid slot keeps input and output sides apart;
// in_stall rises only when both entries hold results.
// Reset clears the ramps to zero and loads the default limit, deadband and step.

module motor_command_shaper_core
    import mcs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [CMD_W-1:0] cmd_ch0,
    input  wire logic signed [CMD_W-1:0] cmd_ch1,
    input  wire logic signed [CMD_W-1:0] cmd_ch2,
    input  wire logic signed [CMD_W-1:0] cmd_ch3,
    input  wire logic signed [CMD_W-1:0] cmd_ch4,
    input  wire logic signed [CMD_W-1:0] cmd_ch5,
    input  wire logic signed [CMD_W-1:0] cmd_ch6,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [MAG_W-1:0]             pwm_ch0,
    output logic [MAG_W-1:0]             pwm_ch1,
    output logic [MAG_W-1:0]             pwm_ch2,
    output logic [MAG_W-1:0]             pwm_ch3,
    output logic [MAG_W-1:0]             pwm_ch4,
    output logic [MAG_W-1:0]             pwm_ch5,
    output logic [MAG_W-1:0]             pwm_ch6,
    output logic [DIR_W-1:0]             dir_ch0,
    output logic [DIR_W-1:0]             dir_ch1,
    output logic [DIR_W-1:0]             dir_ch2,
    output logic [DIR_W-1:0]             dir_ch3,
    output logic [DIR_W-1:0]             dir_ch4,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [MAG_W-1:0]        cfg_data
);

    cfg_t                           cfg_reg;
    cfg_t                           cfg_next;
    logic signed [NUM_CH-1:0][CMD_W-1:0] cmds;
    val_t [NUM_CH-1:0]              targets;
    val_t [NUM_CH-1:0]              vals;
    logic                           accept;
    logic                           busy;
    result_t                        result;

    // Register writes; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLAMP_LIMIT: cfg_next.clamp_limit = cfg_data;
                REG_DEADBAND:    cfg_next.deadband    = cfg_data;
                REG_SLEW_STEP:   cfg_next.slew_step   = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_limit <= CLAMP_LIMIT_RST;
            cfg_reg.deadband    <= DEADBAND_RST;
            cfg_reg.slew_step   <= SLEW_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign accept    = in_valid && !busy;

    assign cmds[0] = cmd_ch0;
    assign cmds[1] = cmd_ch1;
    assign cmds[2] = cmd_ch2;
    assign cmds[3] = cmd_ch3;
    assign cmds[4] = cmd_ch4;
    assign cmds[5] = cmd_ch5;
    assign cmds[6] = cmd_ch6;

    // Condition every channel side by side
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        mcs_lane u_lane (
            .cmd    (cmds[g]),
            .cfg    (cfg_reg),
            .target (targets[g])
        );
    end

    // Pass the drive channels straight through
    for (genvar g = 0; g < FIRST_RAMP; g++)
    begin : g_direct
        assign vals[g] = targets[g];
    end

    // Ramp the last three channels
    for (genvar g = FIRST_RAMP; g < NUM_CH; g++)
    begin : g_ramp
        mcs_ramp u_ramp (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (accept),
            .target     (targets[g]),
            .slew_step  (cfg_reg.slew_step),
            .value_next (vals[g])
        );
    end

    mcs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .vals      (vals),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .result    (result)
    );

    assign pwm_ch0 = result.pwm[0];
    assign pwm_ch1 = result.pwm[1];
    assign pwm_ch2 = result.pwm[2];
    assign pwm_ch3 = result.pwm[3];
    assign pwm_ch4 = result.pwm[4];
    assign pwm_ch5 = result.pwm[5];
    assign pwm_ch6 = result.pwm[6];
    assign dir_ch0 = result.dir[0];
    assign dir_ch1 = result.dir[1];
    assign dir_ch2 = result.dir[2];
    assign dir_ch3 = result.dir[3];
    assign dir_ch4 = result.dir[4];

endmodule

`default_nettype wire

/* test/mcs_output_checker.sv */
module mcs_output_checker
    import mcs_pkg::*;
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [NUM_CH-1:0][CMD_W-1:0]     cmd_bus,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [NUM_CH-1:0][MAG_W-1:0]     pwm_bus,
    input  wire logic [NUM_DIR-1:0][DIR_W-1:0]    dir_bus,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [IDX_W-1:0]                 cfg_index,
    input  wire logic [MAG_W-1:0]                 cfg_data,
    output int                                    error_count,
    output int                                    pending
);

    // Local copy of the shaping settings and the ramp levels
    cfg_t    settings;
    val_t    ramp_level [NUM_RAMP];
    result_t predicted_q [$];

    // Clamp to the limit, then zero anything inside the deadband
    function automatic val_t condition_command(input logic [CMD_W-1:0] raw);
        int v;
        int lim;
        int db;
        int mag;
        v   = $signed(raw);
        lim = settings.clamp_limit;
        db  = settings.deadband;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        mag = (v < 0) ? -v : v;
        if (mag < db)
            v = 0;
        return val_t'(v);
    endfunction

    // Move a ramp toward its target by at most one step, never past it
    function automatic val_t advance_ramp(input val_t level, input val_t target);
        int cur;
        int tgt;
        int stp;
        cur = level;
        tgt = target;
        stp = settings.slew_step;
        if (cur > tgt) begin
            cur = cur - stp;
            if (cur < tgt)
                cur = tgt;
        end
        else if (cur < tgt) begin
            cur = cur + stp;
            if (cur > tgt)
                cur = tgt;
        end
        return val_t'(cur);
    endfunction

    // Work out the PWM and direction outputs of one request, advancing the ramps
    function automatic result_t shape_request(input logic [NUM_CH-1:0][CMD_W-1:0] cmds);
        result_t res;
        val_t    level;
        int      mag;
        int      ch;
        res = '0;
        for (ch = 0; ch < NUM_CH; ch++) begin
            level = condition_command(cmds[ch]);
            if (ch >= FIRST_RAMP) begin
                ramp_level[ch - FIRST_RAMP] = advance_ramp(ramp_level[ch - FIRST_RAMP], level);
                level = ramp_level[ch - FIRST_RAMP];
            end
            mag = level;
            if (mag < 0)
                mag = -mag;
            res.pwm[ch] = mag[MAG_W-1:0];
            if (ch < NUM_DIR) begin
                if (level > 0)
                    res.dir[ch] = DIR_FORWARD;
                else if (level < 0)
                    res.dir[ch] = DIR_REVERSE;
                else
                    res.dir[ch] = DIR_STOP;
            end
        end
        return res;
    endfunction

    // Track register writes, predict each request, compare each result
    always @(posedge clk or negedge rst_n) begin : watch_channels
        result_t want;
        result_t got;
        int      ch;
        int      r;
        if (!rst_n) begin
            settings.clamp_limit = CLAMP_LIMIT_RST;
            settings.deadband    = DEADBAND_RST;
            settings.slew_step   = SLEW_STEP_RST;
            for (r = 0; r < NUM_RAMP; r++)
                ramp_level[r] = '0;
            predicted_q.delete();
            error_count = 0;
            pending     = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLAMP_LIMIT: settings.clamp_limit = cfg_data;
                    REG_DEADBAND:    settings.deadband    = cfg_data;
                    REG_SLEW_STEP:   settings.slew_step   = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predicted_q.push_back(shape_request(cmd_bus));

            if (out_valid && !out_stall) begin
                got.pwm = pwm_bus;
                got.dir = dir_bus;
                if (predicted_q.size() == 0) begin
                    $display("%0t: result arrived with no request outstanding", $time);
                    error_count++;
                end
                else begin
                    want = predicted_q.pop_front();
                    for (ch = 0; ch < NUM_CH; ch++) begin
                        if (got.pwm[ch] !== want.pwm[ch]) begin
                            $display("%0t: pwm_ch%0d expected %0d got %0d",
                                     $time, ch, want.pwm[ch], got.pwm[ch]);
                            error_count++;
                        end
                    end
                    for (ch = 0; ch < NUM_DIR; ch++) begin
                        if (got.dir[ch] !== want.dir[ch]) begin
                            $display("%0t: dir_ch%0d expected %0d got %0d",
                                     $time, ch, want.dir[ch], got.dir[ch]);
                            error_count++;
                        end
                    end
                end
            end
            pending = predicted_q.size();
        end
    end

endmodule

/* test/tb_motor_command_shaper_core.sv */
module tb_motor_command_shaper_core
    import mcs_pkg::*;
;

    typedef logic [NUM_CH-1:0][CMD_W-1:0] cmd_set_t;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int LONG_HOLD       = 40;

    // Settings per phase; a negative entry means draw it at random
    localparam int PHASE_LIMIT [NUM_PHASES] = '{1919, 4095, 0, 100, 2000, 1, 4095, -1, -1, -1};
    localparam int PHASE_DEADBAND [NUM_PHASES] = '{150, 0, 0, 200, 50, 1, 4095, -1, -1, -1};
    localparam int PHASE_SLEW [NUM_PHASES] = '{16, 4095, 1, 7, 0, 4095, 1, -1, -1, -1};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    cmd_set_t                       cmd_bus;
    logic                           out_valid;
    logic                           out_stall;
    wire  [NUM_CH-1:0][MAG_W-1:0]   pwm_bus;
    wire  [NUM_DIR-1:0][DIR_W-1:0]  dir_bus;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [IDX_W-1:0]               cfg_index;
    logic [MAG_W-1:0]               cfg_data;
    int                             error_count;
    int                             pending;

    // Stimulus shaping state
    logic                           sender_burst;
    int                             cur_limit;
    int                             cur_deadband;
    logic [CMD_W-1:0]               ramp_target [NUM_RAMP];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    motor_command_shaper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_ch0   (cmd_bus[0]),
        .cmd_ch1   (cmd_bus[1]),
        .cmd_ch2   (cmd_bus[2]),
        .cmd_ch3   (cmd_bus[3]),
        .cmd_ch4   (cmd_bus[4]),
        .cmd_ch5   (cmd_bus[5]),
        .cmd_ch6   (cmd_bus[6]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pwm_ch0   (pwm_bus[0]),
        .pwm_ch1   (pwm_bus[1]),
        .pwm_ch2   (pwm_bus[2]),
        .pwm_ch3   (pwm_bus[3]),
        .pwm_ch4   (pwm_bus[4]),
        .pwm_ch5   (pwm_bus[5]),
        .pwm_ch6   (pwm_bus[6]),
        .dir_ch0   (dir_bus[0]),
        .dir_ch1   (dir_bus[1]),
        .dir_ch2   (dir_bus[2]),
        .dir_ch3   (dir_bus[3]),
        .dir_ch4   (dir_bus[4]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mcs_output_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd_bus     (cmd_bus),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_bus     (pwm_bus),
        .dir_bus     (dir_bus),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    // Build one request from seven per-channel commands
    function automatic cmd_set_t spread(input int v0, input int v1, input int v2,
                                        input int v3, input int v4, input int v5,
                                        input int v6);
        cmd_set_t c;
        c[0] = v0[CMD_W-1:0];
        c[1] = v1[CMD_W-1:0];
        c[2] = v2[CMD_W-1:0];
        c[3] = v3[CMD_W-1:0];
        c[4] = v4[CMD_W-1:0];
        c[5] = v5[CMD_W-1:0];
        c[6] = v6[CMD_W-1:0];
        return c;
    endfunction

    // Draw one command, leaning on the clamp and deadband edges
    function automatic logic [CMD_W-1:0] pick_command();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: v = $urandom_range(0, 65535);
            3, 4:    v = cur_limit + $urandom_range(0, 4) - 2;
            5, 6:    v = cur_deadband + $urandom_range(0, 4) - 2;
            7:       v = $urandom_range(0, 4095);
            8:       v = $urandom_range(0, 63);
            default: v = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
        endcase
        if (sel >= 3 && sel <= 8 && $urandom_range(0, 1) == 1)
            v = -v;
        return v[CMD_W-1:0];
    endfunction

    // Hold ramp targets steady for long runs so the ramps can settle
    function automatic cmd_set_t random_request();
        cmd_set_t c;
        int       ch;
        int       r;
        for (ch = 0; ch < FIRST_RAMP; ch++)
            c[ch] = pick_command();
        for (r = 0; r < NUM_RAMP; r++) begin
            if ($urandom_range(0, 31) == 0)
                ramp_target[r] = pick_command();
            if ($urandom_range(0, 7) == 0)
                c[FIRST_RAMP + r] = pick_command();
            else
                c[FIRST_RAMP + r] = ramp_target[r];
        end
        return c;
    endfunction

    // Offer one request after a random gap (none in burst mode) and hold it until taken
    task automatic send_request(input cmd_set_t cmds);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd_bus  <= cmds;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[MAG_W-1:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        if (idx == REG_CLAMP_LIMIT)
            cur_limit = value;
        else if (idx == REG_DEADBAND)
            cur_deadband = value;
    endtask

    // Drain: wait until every predicted result has come out
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Result side: random stalls, stall-free windows, and two long holds
    initial begin : result_sink
        int wait_cycles;
        int taken;
        taken     = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (taken == 300 || taken == 1100)
                wait_cycles = LONG_HOLD;
            else if ((taken / 256) % 4 == 2)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 3);
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            taken++;
            @(negedge clk);
        end
    end

    // Request side: directed items, then random phases under varied settings
    initial begin : stimulus
        int p;
        int i;
        int lim;
        int db;
        int stp;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd_bus      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CLAMP_LIMIT;
        cfg_data     = '0;
        sender_burst = 1'b0;
        cur_limit    = CLAMP_LIMIT_RST;
        cur_deadband = DEADBAND_RST;
        for (i = 0; i < NUM_RAMP; i++)
            ramp_target[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Field extremes and clamp/deadband edges at the reset settings
        send_request(spread(0, 0, 0, 0, 0, 0, 0));
        send_request(spread(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_request(spread(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_request(spread(1, 1, 1, 1, 1, 1, 1));
        send_request(spread(-1, -1, -1, -1, -1, -1, -1));
        send_request(spread(1919, -1919, 1920, -1920, 1919, -1920, 1920));
        send_request(spread(150, -150, 149, -149, 151, -151, 150));
        send_request(spread(4095, -4095, -150, 149, -149, 149, -151));
        send_request(spread(21845, 21845, 21845, 21845, 21845, 21845, 21845));
        send_request(spread(-21846, -21846, -21846, -21846, -21846, -21846, -21846));
        // Ramps up, reverse through zero, then back toward stop
        repeat (3) send_request(spread(300, -300, 0, 0, 300, -300, 1919));
        repeat (3) send_request(spread(0, 0, 300, -300, -300, 300, -1919));
        repeat (2) send_request(spread(0, 0, 0, 0, 0, 0, 0));

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                lim = PHASE_LIMIT[p];
                db  = PHASE_DEADBAND[p];
                stp = PHASE_SLEW[p];
                if (lim < 0)
                    lim = $urandom_range(0, 4095);
                if (db < 0)
                    db = $urandom_range(0, lim);
                if (stp < 0)
                    stp = $urandom_range(0, 255);
                if (p == 7)
                    write_reg(REG_UNUSED, $urandom_range(0, 4095));
                write_reg(REG_CLAMP_LIMIT, lim);
                write_reg(REG_DEADBAND, db);
                write_reg(REG_SLEW_STEP, stp);
                cfg_valid <= 1'b0;
                @(negedge clk);
            end
            sender_burst = (p % 3 == 1);
            for (i = 0; i < NUM_RAMP; i++)
                ramp_target[i] = pick_command();
            repeat (ITEMS_PER_PHASE) send_request(random_request());
            in_valid <= 1'b0;
        end

        drain();
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
